[hdl/ira_pkg.sv]
// ----------------------------------------------------------------------------
// ira_pkg
// Shared constants, types and command/status bundles for the room assigner.
// ----------------------------------------------------------------------------
package ira_pkg;

  localparam int MAX_ROOMS = 64;

  localparam int TIME_W = 32;
  localparam int TAG_W  = 16;
  localparam int ROOM_W = 7;
  localparam int OUTC_W = 2;

  // room index into the busy-until store, and a count that can hold MAX_ROOMS
  localparam int IDX_W = (MAX_ROOMS > 1) ? $clog2(MAX_ROOMS) : 1;
  localparam int CNT_W = $clog2(MAX_ROOMS + 1);

  typedef enum logic [OUTC_W-1:0] {
    OUTCOME_REUSED = 2'd0,
    OUTCOME_OPENED = 2'd1,
    OUTCOME_FULL   = 2'd2,
    OUTCOME_ORDER  = 2'd3
  } outcome_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture the request
    logic scan_init;  // restart the scan, forget the best candidate
    logic issue;      // read the next room
    logic commit;     // apply the decision and load the result register
  } ira_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic order_bad;  // arrival earlier than the last accepted one
    logic none_open;  // no room opened yet
    logic issue_last; // the room being read now is the last opened one
    logic out_free;   // result register free this cycle
  } ira_stat_t;

endpackage

[hdl/ira_if.sv]
// ----------------------------------------------------------------------------
// ira_if
// Request and result channels: valid/ready handshake with payload.
// ----------------------------------------------------------------------------
interface ira_req_if import ira_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] arrival_time;
  logic [TIME_W-1:0] departure_time;
  logic [TAG_W-1:0]  request_tag;

  modport source (output valid, arrival_time, departure_time, request_tag, input ready);
  modport sink   (input valid, arrival_time, departure_time, request_tag, output ready);
endinterface

interface ira_res_if import ira_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ROOM_W-1:0] room_number;
  logic [TAG_W-1:0]  result_tag;
  logic [OUTC_W-1:0] outcome;
  logic [ROOM_W-1:0] rooms_in_use;

  modport source (output valid, room_number, result_tag, outcome, rooms_in_use, input ready);
  modport sink   (input valid, room_number, result_tag, outcome, rooms_in_use, output ready);
endinterface

[hdl/ira_ram.sv]
// ----------------------------------------------------------------------------
// ira_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ira_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic                                     rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hdl/ira_ctrl.sv]
// ----------------------------------------------------------------------------
// ira_ctrl
// Sequencer: accept, check order, scan opened rooms, decide.
// ----------------------------------------------------------------------------
module ira_ctrl import ira_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  ira_stat_t stat,
  output ira_cmd_t  cmd
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_CHECK  = 5'b00010,
    ST_SCAN   = 5'b00100,
    ST_DRAIN  = 5'b01000,
    ST_DECIDE = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        cmd.load  = req_valid;
        if (req_valid) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.scan_init = 1'b1;
        if (stat.order_bad || stat.none_open) begin
          state_next = ST_DECIDE;
        end else begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.issue = 1'b1;
        if (stat.issue_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        // hold until the result register can take the new transfer
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[hdl/ira_datapath.sv]
// ----------------------------------------------------------------------------
// ira_datapath
// Request registers, busy-until store, minimum search and result register.
// ----------------------------------------------------------------------------
module ira_datapath import ira_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  ira_cmd_t          cmd,
  output ira_stat_t         stat,
  input  logic [TIME_W-1:0] arrival_time,
  input  logic [TIME_W-1:0] departure_time,
  input  logic [TAG_W-1:0]  request_tag,
  output logic              res_valid,
  input  logic              res_ready,
  output logic [ROOM_W-1:0] room_number,
  output logic [TAG_W-1:0]  result_tag,
  output logic [OUTC_W-1:0] outcome,
  output logic [ROOM_W-1:0] rooms_in_use
);

  logic [TIME_W-1:0] arrival;
  logic [TIME_W-1:0] departure;
  logic [TAG_W-1:0]  tag;
  logic [TIME_W-1:0] prev_arrival;
  logic [CNT_W-1:0]  opened;

  logic [IDX_W-1:0]  issue_idx;
  logic              pend;
  logic [IDX_W-1:0]  pend_idx;
  logic              have_best;
  logic [TIME_W-1:0] best_time;
  logic [IDX_W-1:0]  best_idx;

  logic [TIME_W-1:0] rd_data;
  logic              take;

  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [CNT_W-1:0]  room_sel;
  logic [CNT_W-1:0]  opened_next;
  outcome_t          outc_sel;
  logic              advance;

  ira_ram #(
    .WIDTH (TIME_W),
    .DEPTH (MAX_ROOMS)
  ) u_busy_until (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (departure),
    .rd_en   (cmd.issue),
    .rd_addr (issue_idx),
    .rd_data (rd_data)
  );

  assign stat.order_bad  = arrival < prev_arrival;
  assign stat.none_open  = opened == '0;
  assign stat.issue_last = issue_idx == IDX_W'(opened - CNT_W'(1));
  assign stat.out_free   = !res_valid || res_ready;

  // later rooms win ties
  assign take = pend && (!have_best || rd_data <= best_time);

  always_comb begin
    wr_en       = 1'b0;
    wr_addr     = best_idx;
    room_sel    = '0;
    opened_next = opened;
    advance     = 1'b0;
    priority if (arrival < prev_arrival) begin
      outc_sel = OUTCOME_ORDER;
    end else if (have_best && best_time < arrival) begin
      outc_sel = OUTCOME_REUSED;
      wr_en    = cmd.commit;
      room_sel = CNT_W'(best_idx) + CNT_W'(1);
      advance  = 1'b1;
    end else if (opened < CNT_W'(MAX_ROOMS)) begin
      outc_sel    = OUTCOME_OPENED;
      wr_en       = cmd.commit;
      wr_addr     = IDX_W'(opened);
      opened_next = opened + CNT_W'(1);
      room_sel    = opened_next;
      advance     = 1'b1;
    end else begin
      outc_sel = OUTCOME_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_arrival <= '0;
      opened       <= '0;
      pend         <= 1'b0;
      have_best    <= 1'b0;
      res_valid    <= 1'b0;
    end else begin
      pend <= cmd.issue;
      if (cmd.scan_init) begin
        have_best <= 1'b0;
      end else if (take) begin
        have_best <= 1'b1;
      end
      if (cmd.commit) begin
        opened <= opened_next;
        if (advance) begin
          prev_arrival <= arrival;
        end
      end
      if (cmd.commit) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      arrival   <= arrival_time;
      departure <= departure_time;
      tag       <= request_tag;
    end
    if (cmd.scan_init) begin
      issue_idx <= '0;
    end else if (cmd.issue) begin
      issue_idx <= issue_idx + IDX_W'(1);
    end
    pend_idx <= issue_idx;
    if (take) begin
      best_time <= rd_data;
      best_idx  <= pend_idx;
    end
    if (cmd.commit) begin
      room_number  <= ROOM_W'(room_sel);
      result_tag   <= tag;
      outcome      <= outc_sel;
      rooms_in_use <= ROOM_W'(opened_next);
    end
  end

endmodule

[hdl/interval_room_assigner_unit.sv]
// ----------------------------------------------------------------------------
// interval_room_assigner_unit
// Assigns arrival-ordered booking requests to the fewest rooms.
// ----------------------------------------------------------------------------
// Channels: req carries arrival_time, departure_time and request_tag; res
// returns room_number, result_tag, outcome and rooms_in_use, one transfer
// per request. Both use valid/ready; a transfer happens when both are high.
// Each request reads the busy-until time of every opened room, one room per
// cycle through the single read port of the busy-until RAM, keeping the
// earliest (latest room on ties); the room is reused if that time is before
// the arrival, otherwise a new room is opened.
// Sequencing: accept, order check, a read of every opened room and a drain
// state, then the decision; a request out of order or with no room open yet
// goes from the check straight to the decision. The next request is accepted
// only after that decision. The result appears the cycle after the decision.
// Reset (rst, synchronous): clears the room count, the last arrival and the
// result valid; the RAM holds no meaningful data until rooms are opened.
// Receiver stall: the result register holds its transfer; the next request
// is still accepted and worked on, and waits at its decision until the
// register is free.
// ----------------------------------------------------------------------------
module interval_room_assigner_unit import ira_pkg::*; (
  input logic   clk,
  input logic   rst,
  ira_req_if.sink   req,
  ira_res_if.source res
);

  ira_cmd_t  cmd;
  ira_stat_t stat;

  // sequence the work of one request
  ira_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // hold the request, scan the rooms and drive the result register
  ira_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .arrival_time   (req.arrival_time),
    .departure_time (req.departure_time),
    .request_tag    (req.request_tag),
    .res_valid      (res.valid),
    .res_ready      (res.ready),
    .room_number    (res.room_number),
    .result_tag     (res.result_tag),
    .outcome        (res.outcome),
    .rooms_in_use   (res.rooms_in_use)
  );

endmodule
